### design/scmr_pkg.sv
// Shared types and constants for the serial command motor ramp block.
package scmr_pkg;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_S     = 8'h53;

    localparam logic [15:0] RAMP_INTERVAL_RESET = 16'd100;

    localparam logic [2:0] TOKEN_MAX   = 3'd7;
    localparam logic [2:0] TOKEN_LEFT  = 3'd2;
    localparam logic [2:0] TOKEN_RIGHT = 3'd4;
    localparam logic [2:0] TOKEN_MIN   = 3'd4;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] left_drive;
        logic [7:0] right_drive;
        logic       left_update;
        logic       right_update;
        logic       cmd_accepted;
    } out_item_t;

    typedef struct packed {
        logic       set;
        logic [7:0] left;
        logic [7:0] right;
    } cmd_t;

    typedef struct packed {
        logic [7:0] left_level;
        logic [7:0] right_level;
        logic       left_update;
        logic       right_update;
    } ramp_status_t;

endpackage

### design/scmr_parser.sv
// Line assembler and command parser: builds targets from an 'S' command line.
module scmr_parser #(
    parameter int LINE_CHARS = 31
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_en,
    input  logic [7:0]        rx_byte,
    output scmr_pkg::cmd_t    cmd
);

    localparam int PosW = $clog2(LINE_CHARS + 1);

    typedef struct packed {
        logic [7:0]      acc;
        scmr_pkg::phase_t phase;
        logic            neg;
    } num_t;

    logic [PosW-1:0]  pos_reg, pos_next;
    logic             ended_reg, ended_next;
    logic             is_cmd_reg, is_cmd_next;
    logic             in_tok_reg, in_tok_next;
    logic [2:0]       tok_reg, tok_next;
    scmr_pkg::phase_t phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [7:0]       lacc_reg, lacc_next;
    logic [7:0]       racc_reg, racc_next;

    function automatic num_t number_char(num_t s, logic [7:0] c);
        num_t       r;
        logic [7:0] d;
        logic [7:0] t;
        r = s;
        d = c - scmr_pkg::CHAR_ZERO;
        t = s.acc * 8'd10;
        if (r.phase == scmr_pkg::PH_SKIP) begin
            if (c == scmr_pkg::CHAR_TAB || c == scmr_pkg::CHAR_VT ||
                c == scmr_pkg::CHAR_FF || c == scmr_pkg::CHAR_CR) begin
                return r;
            end
            if (c == scmr_pkg::CHAR_PLUS || c == scmr_pkg::CHAR_MINUS) begin
                r.neg   = (c == scmr_pkg::CHAR_MINUS);
                r.phase = scmr_pkg::PH_DIGITS;
                return r;
            end
            r.phase = scmr_pkg::PH_DIGITS;
        end
        if (r.phase == scmr_pkg::PH_DIGITS) begin
            if (c >= scmr_pkg::CHAR_ZERO && c <= scmr_pkg::CHAR_NINE) begin
                r.acc = r.neg ? (t - d) : (t + d);
            end else begin
                r.phase = scmr_pkg::PH_DONE;
            end
        end
        return r;
    endfunction

    always_comb
    begin
        num_t             ns;
        num_t             nr;
        logic [2:0]       tok_t;
        scmr_pkg::phase_t ph_t;
        logic             neg_t;

        pos_next    = pos_reg;
        ended_next  = ended_reg;
        is_cmd_next = is_cmd_reg;
        in_tok_next = in_tok_reg;
        tok_next    = tok_reg;
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        lacc_next   = lacc_reg;
        racc_next   = racc_reg;
        cmd.set     = 1'b0;
        cmd.left    = lacc_reg;
        cmd.right   = racc_reg;
        tok_t       = tok_reg;
        ph_t        = phase_reg;
        neg_t       = neg_reg;
        ns          = '0;
        nr          = '0;

        if (byte_en) begin
            if (rx_byte == scmr_pkg::CHAR_LF) begin
                cmd.set     = is_cmd_reg && (tok_reg >= scmr_pkg::TOKEN_MIN);
                pos_next    = '0;
                ended_next  = 1'b0;
                is_cmd_next = 1'b0;
                in_tok_next = 1'b0;
                tok_next    = '0;
                phase_next  = scmr_pkg::PH_SKIP;
                neg_next    = 1'b0;
                lacc_next   = '0;
                racc_next   = '0;
            end else if (!ended_reg && pos_reg < PosW'(LINE_CHARS)) begin
                pos_next = pos_reg + 1'b1;
                if (rx_byte == scmr_pkg::CHAR_NUL) begin
                    ended_next = 1'b1;
                end else begin
                    if (pos_reg == '0 && rx_byte == scmr_pkg::CHAR_S) begin
                        is_cmd_next = 1'b1;
                    end
                    if (rx_byte == scmr_pkg::CHAR_SPACE) begin
                        in_tok_next = 1'b0;
                    end else begin
                        // open a new token and restart number reading
                        if (!in_tok_reg) begin
                            in_tok_next = 1'b1;
                            if (tok_reg < scmr_pkg::TOKEN_MAX) begin
                                tok_t = tok_reg + 3'd1;
                            end
                            ph_t  = scmr_pkg::PH_SKIP;
                            neg_t = 1'b0;
                        end
                        tok_next   = tok_t;
                        phase_next = ph_t;
                        neg_next   = neg_t;
                        if (tok_t == scmr_pkg::TOKEN_LEFT) begin
                            ns.acc   = lacc_reg;
                            ns.phase = ph_t;
                            ns.neg   = neg_t;
                            nr         = number_char(ns, rx_byte);
                            lacc_next  = nr.acc;
                            phase_next = nr.phase;
                            neg_next   = nr.neg;
                        end else if (tok_t == scmr_pkg::TOKEN_RIGHT) begin
                            ns.acc   = racc_reg;
                            ns.phase = ph_t;
                            ns.neg   = neg_t;
                            nr         = number_char(ns, rx_byte);
                            racc_next  = nr.acc;
                            phase_next = nr.phase;
                            neg_next   = nr.neg;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg    <= '0;
            ended_reg  <= 1'b0;
            is_cmd_reg <= 1'b0;
            in_tok_reg <= 1'b0;
            tok_reg    <= '0;
            phase_reg  <= scmr_pkg::PH_SKIP;
            neg_reg    <= 1'b0;
            lacc_reg   <= '0;
            racc_reg   <= '0;
        end else begin
            pos_reg    <= pos_next;
            ended_reg  <= ended_next;
            is_cmd_reg <= is_cmd_next;
            in_tok_reg <= in_tok_next;
            tok_reg    <= tok_next;
            phase_reg  <= phase_next;
            neg_reg    <= neg_next;
            lacc_reg   <= lacc_next;
            racc_reg   <= racc_next;
        end
    end

endmodule

### design/scmr_ramp.sv
// Ramp generator: steps both power levels toward their targets on the tick interval.
module scmr_ramp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   tick_en,
    input  scmr_pkg::cmd_t         cmd,
    input  logic                   cfg_wen,
    input  logic [15:0]            cfg_wdata,
    output scmr_pkg::ramp_status_t status
);

    logic [15:0] interval_reg;
    logic [15:0] tick_reg, tick_next;
    logic [7:0]  lgoal_reg, lgoal_next;
    logic [7:0]  rgoal_reg, rgoal_next;
    logic [7:0]  llev_reg, llev_next;
    logic [7:0]  rlev_reg, rlev_next;
    logic [15:0] tick_inc;

    assign tick_inc = tick_reg + 16'd1;

    always_comb
    begin
        tick_next           = tick_reg;
        llev_next           = llev_reg;
        rlev_next           = rlev_reg;
        lgoal_next          = cmd.set ? cmd.left  : lgoal_reg;
        rgoal_next          = cmd.set ? cmd.right : rgoal_reg;
        status.left_update  = 1'b0;
        status.right_update = 1'b0;
        if (tick_en) begin
            tick_next = tick_inc;
            if (tick_inc == interval_reg) begin
                tick_next = '0;
                if (lgoal_reg > llev_reg) begin
                    llev_next          = llev_reg + 8'd1;
                    status.left_update = 1'b1;
                end else if (lgoal_reg < llev_reg) begin
                    llev_next          = llev_reg - 8'd1;
                    status.left_update = 1'b1;
                end
                if (rgoal_reg > rlev_reg) begin
                    rlev_next           = rlev_reg + 8'd1;
                    status.right_update = 1'b1;
                end else if (rgoal_reg < rlev_reg) begin
                    rlev_next           = rlev_reg - 8'd1;
                    status.right_update = 1'b1;
                end
            end
        end
        status.left_level  = llev_next;
        status.right_level = rlev_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            interval_reg <= scmr_pkg::RAMP_INTERVAL_RESET;
            tick_reg     <= '0;
            lgoal_reg    <= '0;
            rgoal_reg    <= '0;
            llev_reg     <= '0;
            rlev_reg     <= '0;
        end else begin
            if (cfg_wen) begin
                interval_reg <= cfg_wdata;
            end
            tick_reg  <= tick_next;
            lgoal_reg <= lgoal_next;
            rgoal_reg <= rgoal_next;
            llev_reg  <= llev_next;
            rlev_reg  <= rlev_next;
        end
    end

endmodule

### design/serial_command_motor_ramp_top.sv
// Top level of the serial command motor ramp block.
// Takes one item (a serial byte or a loop tick) per clock unless a stalled output holds it,
// and returns exactly one result per item. An accepted item is held in the input register
// and passes through the single update stage, where the line parser and the ramp step both
// finish, into the result register, which lets the next item enter while a result waits.
// The user writes ramp_interval through cfg_wen/cfg_wdata while idle; it is not enforced.
module serial_command_motor_ramp_top #(
    parameter int LINE_CHARS = 31
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  scmr_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output scmr_pkg::out_item_t out_data,
    input  logic                cfg_wen,
    input  logic [15:0]         cfg_wdata
);

    logic                   s1_valid_reg;
    scmr_pkg::in_item_t     s1_item_reg;
    logic                   out_valid_reg;
    scmr_pkg::out_item_t    out_item_reg, out_item_next;
    logic                   advance;
    logic                   byte_en;
    logic                   tick_en;
    scmr_pkg::cmd_t         cmd;
    scmr_pkg::ramp_status_t status;

    // advance the held item whenever the result slot is free or being drained
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign byte_en  = advance && (s1_item_reg.req_type == scmr_pkg::REQ_BYTE);
    assign tick_en  = advance && (s1_item_reg.req_type == scmr_pkg::REQ_TICK);

    scmr_parser #(
        .LINE_CHARS (LINE_CHARS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (byte_en),
        .rx_byte (s1_item_reg.rx_byte),
        .cmd     (cmd)
    );

    scmr_ramp u_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_en   (tick_en),
        .cmd       (cmd),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .status    (status)
    );

    always_comb
    begin
        out_item_next.left_drive   = status.left_level;
        out_item_next.right_drive  = status.right_level;
        out_item_next.left_update  = status.left_update;
        out_item_next.right_update = status.right_update;
        out_item_next.cmd_accepted = cmd.set;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            s1_item_reg <= in_data;
        end
        if (advance) begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // a command result never carries a ramp write
    a_cmd_no_update: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.cmd_accepted |->
            !out_item_reg.left_update && !out_item_reg.right_update)
        else $error("command result flags a ramp write");

    // a held item survives a stalled output
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !out_ready |=> s1_valid_reg)
        else $error("held item dropped while output stalled");

    // input stalls only while an item is held
    a_ready_reason: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled without a held item");

endmodule
